// ----- sv/ssr_pkg.sv -----
// Shared constants and control/status types for the shell sort row block.
// Used by ssr_ctrl, ssr_dp and shell_sort_row; depends on nothing.
package ssr_pkg;

  localparam int MAX_ROW        = 16;
  localparam int IDX_W          = $clog2(MAX_ROW);
  localparam int CNT_W          = $clog2(MAX_ROW + 1);
  localparam int DATA_W         = 16;
  localparam int START_GAP      = 4;
  localparam int GAP_W          = $clog2(START_GAP + 1);
  localparam int LEN_W          = 5;
  localparam int ROW_LENGTH_RST = 10;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(0);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // store incoming sample, bump fill count
    logic sort_start;  // reset sort and emit indexes, gap to start value
    logic fetch;       // read element j
    logic hold;        // latch element j, read its gap predecessor
    logic shift;       // move predecessor up one gap, read the next one
    logic place;       // write held element at its final slot
    logic advance;     // next element, or next pass at the end of a pass
    logic emit_rd;     // read element k for output
    logic emit_out;    // load output register with element k
  } ssr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic row_full;     // fill count reaches the row length with this load
    logic j_ge_gap;     // element j has a gap predecessor
    logic greater;      // predecessor is strictly greater than held element
    logic pos_ge_2gap;  // after a move there is still a predecessor
    logic j_last;       // element j is the last of the row
    logic gap_one;      // current pass is the final one
    logic k_last;       // output index is at the last element
    logic out_free;     // output register can take a value this cycle
  } ssr_stat_t;

endpackage

// ----- sv/ssr_ctrl.sv -----
// Sequencer for the shell sort row block: load, gapped insertion passes, emit.
// Depends on ssr_pkg for the command and status types.
module ssr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssr_pkg::ssr_stat_t stat,
  output ssr_pkg::ssr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_HOLD,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  state_t state_r, state_nxt, adv_state;
  logic   in_stall_r;

  // Where to go once the current element is in place
  assign adv_state = (stat.j_last && stat.gap_one) ? ST_EMIT_RD : ST_FETCH;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.row_full) begin
            cmd.sort_start = 1'b1;
            state_nxt      = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        cmd.hold = 1'b1;
        if (stat.j_ge_gap) begin
          state_nxt = ST_CMP;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = adv_state;
        end
      end
      ST_CMP: begin
        if (stat.greater) begin
          cmd.shift = 1'b1;
          state_nxt = stat.pos_ge_2gap ? ST_CMP : ST_PLACE;
        end else begin
          cmd.place   = 1'b1;
          cmd.advance = 1'b1;
          state_nxt   = adv_state;
        end
      end
      ST_PLACE: begin
        cmd.place   = 1'b1;
        cmd.advance = 1'b1;
        state_nxt   = adv_state;
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        // hold the read address so the read data stays put while stalled
        cmd.emit_rd = 1'b1;
        if (stat.out_free) begin
          cmd.emit_out = 1'b1;
          state_nxt    = stat.k_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_LOAD);
    end
  end

  assign in_stall = in_stall_r;

`ifndef SYNTHESIS
  a_stall_tracks_state : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (state_r != ST_LOAD))
    else $error("input stall out of step with controller state");

  a_full_starts_sort : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && in_valid && stat.row_full) |=> (state_r == ST_FETCH))
    else $error("completed row did not start sorting");

  a_emit_blocks_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_WR && !stat.out_free) |=> (state_r == ST_EMIT_WR))
    else $error("emit advanced while output register was busy");
`endif

endmodule

// ----- sv/ssr_dp.sv -----
// Datapath for the shell sort row block: row store, sort indexes, compare
// and output register. Depends on ssr_pkg; driven by ssr_ctrl commands.
module ssr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssr_pkg::ssr_cmd_t                 cmd,
  output ssr_pkg::ssr_stat_t                stat,
  input  logic [ssr_pkg::LEN_W-1:0]         row_length,
  input  logic signed [ssr_pkg::DATA_W-1:0] sample_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ssr_pkg::DATA_W-1:0] sorted_value,
  output logic                              row_end
);

  logic signed [ssr_pkg::DATA_W-1:0] row_store [ssr_pkg::MAX_ROW];
  logic signed [ssr_pkg::DATA_W-1:0] rdata_r, held_r, out_value_r, wdata;
  logic [ssr_pkg::CNT_W-1:0]         cnt_r, cnt_inc, eff_len;
  logic [ssr_pkg::IDX_W-1:0]         j_r, pos_r, k_r, gap_i, pos_m_gap, raddr, waddr;
  logic [ssr_pkg::GAP_W-1:0]         gap_r;
  logic                              out_valid_r, out_end_r, we, cnt_room;

  // Zero length counts as one, anything above the store size saturates
  always_comb begin
    if (row_length == '0) begin
      eff_len = ssr_pkg::CNT_W'(1);
    end else if (ssr_pkg::CNT_W'(row_length) > ssr_pkg::CNT_W'(ssr_pkg::MAX_ROW)) begin
      eff_len = ssr_pkg::CNT_W'(ssr_pkg::MAX_ROW);
    end else begin
      eff_len = ssr_pkg::CNT_W'(row_length);
    end
  end

  assign cnt_room  = (cnt_r < ssr_pkg::CNT_W'(ssr_pkg::MAX_ROW));
  assign cnt_inc   = cnt_room ? (cnt_r + ssr_pkg::CNT_W'(1)) : cnt_r;
  assign gap_i     = ssr_pkg::IDX_W'(gap_r);
  assign pos_m_gap = pos_r - gap_i;

  assign stat.row_full    = (cnt_inc >= eff_len);
  assign stat.j_ge_gap    = (j_r >= gap_i);
  assign stat.greater     = (rdata_r > held_r);
  assign stat.pos_ge_2gap = (pos_m_gap >= gap_i);
  assign stat.j_last      = ((ssr_pkg::CNT_W'(j_r) + ssr_pkg::CNT_W'(1)) == cnt_r);
  assign stat.gap_one     = (gap_r == ssr_pkg::GAP_W'(1));
  assign stat.k_last      = ((ssr_pkg::CNT_W'(k_r) + ssr_pkg::CNT_W'(1)) == cnt_r);
  assign stat.out_free    = !out_valid_r || !out_stall;

  // Read address for the next cycle's data
  always_comb begin
    if (cmd.hold) begin
      raddr = j_r - gap_i;
    end else if (cmd.shift) begin
      raddr = pos_m_gap - gap_i;
    end else if (cmd.emit_rd) begin
      raddr = k_r;
    end else begin
      raddr = j_r;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = held_r;
    if (cmd.load) begin
      we    = cnt_room;
      waddr = cnt_r[ssr_pkg::IDX_W-1:0];
      wdata = sample_value;
    end else if (cmd.shift) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.place) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      row_store[waddr] <= wdata;
    end
    rdata_r <= row_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      held_r <= rdata_r;
    end
    if (cmd.emit_out) begin
      out_value_r <= rdata_r;
      out_end_r   <= stat.k_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      j_r         <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      gap_r       <= ssr_pkg::GAP_W'(ssr_pkg::START_GAP);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= cnt_inc;
      end
      if (cmd.sort_start) begin
        j_r   <= '0;
        k_r   <= '0;
        gap_r <= ssr_pkg::GAP_W'(ssr_pkg::START_GAP);
      end
      if (cmd.hold) begin
        pos_r <= j_r;
      end else if (cmd.shift) begin
        pos_r <= pos_m_gap;
      end
      if (cmd.advance) begin
        if (stat.j_last) begin
          j_r <= '0;
          if (!stat.gap_one) begin
            gap_r <= gap_r >> 1;
          end
        end else begin
          j_r <= j_r + ssr_pkg::IDX_W'(1);
        end
      end
      if (cmd.emit_out) begin
        if (stat.k_last) begin
          cnt_r <= '0;
        end else begin
          k_r <= k_r + ssr_pkg::IDX_W'(1);
        end
      end
      if (cmd.emit_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign sorted_value = out_value_r;
  assign row_end      = out_end_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ssr_pkg::CNT_W'(ssr_pkg::MAX_ROW))
    else $error("fill count beyond row store size");

  a_gap_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(gap_r))
    else $error("gap is not a power of two");

  a_shift_has_pred : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> (pos_r >= gap_i))
    else $error("element moved from below index zero");

  a_last_marked : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_out && stat.k_last) |=> (out_valid && row_end && cnt_r == '0))
    else $error("last element of row not marked or count not cleared");
`endif

endmodule

// ----- sv/shell_sort_row.sv -----
// Top level of the shell sort row block: configuration register and
// APB-style port, ssr_ctrl sequencer and ssr_dp datapath. Depends on ssr_pkg.
//
// Values arrive one per transaction and are taken one per cycle until the
// configured row length (0 counts as 1, above 16 saturates to 16) is held.
// The transaction that completes the row starts a Shell sort with gaps 4, 2
// and 1 on the single row store, which does one read and one write a cycle:
// each pass fetches and holds every element in turn, compares an element
// that has a predecessor one gap back with it, moves the predecessor up one
// gap on each compare that finds it greater, then places the held element.
// The sorted row then leaves ascending, each value read from the store and
// then loaded into the output register once it is free, with row_end on the
// last one. Input is stalled from the completing transaction until the last
// value is in the output register, which holds it while the next row loads.
// Write row_length only while no row is in progress.
module shell_sort_row (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ssr_pkg::DATA_W-1:0]     in_sample_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ssr_pkg::DATA_W-1:0]     out_sorted_value,
  output logic                                  out_row_end,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ssr_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [ssr_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  ssr_pkg::ssr_cmd_t          cmd;
  ssr_pkg::ssr_stat_t         stat;
  logic [ssr_pkg::LEN_W-1:0]  row_length_r;
  logic [ssr_pkg::CFG_IDX_W-1:0] reg_idx;
  logic                       reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ssr_pkg::CFG_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ssr_pkg::LEN_W'(ssr_pkg::ROW_LENGTH_RST);
    end else if (reg_wr && reg_idx == ssr_pkg::REG_ROW_LENGTH) begin
      row_length_r <= pwdata[ssr_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      ssr_pkg::REG_ROW_LENGTH: prdata = ssr_pkg::CFG_DATA_W'(row_length_r);
      default:                 prdata = '0;
    endcase
  end

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .row_length   (row_length_r),
    .sample_value (in_sample_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (out_sorted_value),
    .row_end      (out_row_end)
  );

endmodule

// ----- tb/ssr_row_checker.sv -----
// Scoreboard for shell_sort_row: follows the row_length register on the config bus,
// keeps its own row store, sorts each completed row and checks every output transaction.
// Depends on ssr_pkg for widths and register indexes.
module ssr_row_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [ssr_pkg::DATA_W-1:0] in_sample_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [ssr_pkg::DATA_W-1:0] out_sorted_value,
  input  logic                              out_row_end,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]    pwdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                pending,
  output int                                values_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [ssr_pkg::DATA_W-1:0] value;
    logic                              row_end;
  } sorted_entry_t;

  sorted_entry_t                     sorted_expect_q[$];
  logic signed [ssr_pkg::DATA_W-1:0] row_vals [ssr_pkg::MAX_ROW];
  int                                held_count;
  logic [ssr_pkg::LEN_W-1:0]         row_len_q;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Gapped insertion passes 4, 2, 1 over the held values, then queue them in order.
  task automatic predict_sorted_row();
    logic signed [ssr_pkg::DATA_W-1:0] held;
    int pos;
    for (int gap = ssr_pkg::START_GAP; gap >= 1; gap = gap / 2) begin
      for (int j = 0; j < held_count; j++) begin
        held = row_vals[j];
        pos = j;
        while (pos >= gap && row_vals[pos - gap] > held) begin
          row_vals[pos] = row_vals[pos - gap];
          pos = pos - gap;
        end
        row_vals[pos] = held;
      end
    end
    for (int k = 0; k < held_count; k++) begin
      sorted_expect_q.push_back(sorted_entry_t'{row_vals[k], (k + 1 == held_count)});
    end
    held_count = 0;
  endtask

  always @(posedge clk) begin
    sorted_entry_t exp_entry;
    int fill_target;
    if (!rst_n) begin
      sorted_expect_q.delete();
      held_count = 0;
      row_len_q = ssr_pkg::LEN_W'(ssr_pkg::ROW_LENGTH_RST);
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[ssr_pkg::CFG_ADDR_W-1:2] == ssr_pkg::REG_ROW_LENGTH) begin
        row_len_q = pwdata[ssr_pkg::LEN_W-1:0];
      end
      if (out_valid && !out_stall) begin
        values_checked++;
        if (sorted_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected sorted value %0d row_end %0b",
                                    out_sorted_value, out_row_end));
        end else begin
          exp_entry = sorted_expect_q.pop_front();
          if (out_sorted_value !== exp_entry.value)
            report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                      out_sorted_value, exp_entry.value));
          if (out_row_end !== exp_entry.row_end)
            report_mismatch($sformatf("row_end %0b, expected %0b on value %0d",
                                      out_row_end, exp_entry.row_end, exp_entry.value));
        end
      end
      if (in_valid && !in_stall) begin
        // zero counts as one, anything above the store size saturates
        fill_target = (row_len_q == 0) ? 1 :
                      (row_len_q > ssr_pkg::MAX_ROW) ? ssr_pkg::MAX_ROW : row_len_q;
        if (held_count < ssr_pkg::MAX_ROW) begin
          row_vals[held_count] = in_sample_value;
          held_count++;
        end
        if (held_count >= fill_target) predict_sorted_row();
      end
    end
    pending = sorted_expect_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the shell_sort_row testbench: clock, reset, config writes and row stimulus,
// random idling on both channels. Instantiates shell_sort_row and ssr_row_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_EXTREME, PAT_RISING, PAT_FALLING}
    sample_pattern_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [ssr_pkg::DATA_W-1:0] in_sample_value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [ssr_pkg::DATA_W-1:0] out_sorted_value;
  logic                              out_row_end;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [ssr_pkg::CFG_ADDR_W-1:0]    paddr = '0;
  logic [ssr_pkg::CFG_DATA_W-1:0]    pwdata = '0;
  logic [ssr_pkg::CFG_DATA_W-1:0]    prdata;
  logic                              pready;

  int        fail_count;
  int        pending;
  int        values_checked;
  int        cycle_count = 0;
  int        samples_sent = 0;
  bit        gaps_on = 1'b1;
  bit        hold_out = 1'b0;
  bit [31:0] lengths_seen = '0;

  shell_sort_row dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_row_end      (out_row_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  ssr_row_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_row_end      (out_row_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending          (pending),
    .values_checked   (values_checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("shell_sort_row test failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        for (int c = 1; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 38);
      end
    end
  end

  function automatic int row_fill(input int len);
    return (len == 0) ? 1 : (len > ssr_pkg::MAX_ROW) ? ssr_pkg::MAX_ROW : len;
  endfunction

  // Offer one transaction and hold it until accepted; valid stays high afterwards.
  task automatic send_sample(input int v);
    while (gaps_on && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= ssr_pkg::DATA_W'(v);
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic write_row_length(input int len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ssr_pkg::CFG_ADDR_W'(ssr_pkg::REG_ROW_LENGTH) << 2;
    pwdata  <= ssr_pkg::CFG_DATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    lengths_seen[len] = 1'b1;
  endtask

  // Drop valid and wait until every sorted value has come out, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_row(input int fill, input sample_pattern_t pat);
    int v;
    for (int k = 0; k < fill; k++) begin
      case (pat)
        PAT_NARROW:  v = $urandom_range(0, 8) - 4;
        PAT_RISING:  v = -32768 + k * 4000 + $urandom_range(0, 99);
        PAT_FALLING: v = 32767 - k * 4000 - $urandom_range(0, 99);
        PAT_EXTREME: begin
          case ($urandom_range(0, 3))
            0:       v = 32767;
            1:       v = -32768;
            2:       v = 0;
            default: v = -1;
          endcase
        end
        default:     v = $urandom;
      endcase
      send_sample(v);
    end
  endtask

  initial begin
    int directed_row [10] = '{-32768, 32767, 0, -1, 1, 32767, -32768, 5, 5, -2};
    int len;
    int rows;
    int phase;
    int random_start;
    sample_pattern_t pat;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of 10: extremes and duplicates in one row
    foreach (directed_row[i]) send_sample(directed_row[i]);
    drain_results();
    // single-value rows, with zero standing for one, then short rows of 2 and 4
    write_row_length(1);
    send_sample(100);
    send_sample(-100);
    drain_results();
    write_row_length(0);
    send_sample(7);
    drain_results();
    write_row_length(2);
    send_sample(3);
    send_sample(-3);
    drain_results();
    write_row_length(4);
    repeat (4) send_sample(9);
    drain_results();

    // hold the output while full rows keep coming, so the input backs up
    random_start = samples_sent;
    write_row_length(ssr_pkg::MAX_ROW);
    hold_out = 1'b1;
    gaps_on = 1'b0;
    repeat (3) send_row(ssr_pkg::MAX_ROW, PAT_FALLING);
    drain_results();
    gaps_on = 1'b1;

    phase = 0;
    while (samples_sent - random_start < RANDOM_ITEMS) begin
      if (phase == 0) begin
        len = 31;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: len = $urandom_range(1, 4);
          3, 4, 5: len = $urandom_range(5, 12);
          6, 7:    len = $urandom_range(13, 16);
          8:       len = 0;
          default: len = $urandom_range(17, 31);
        endcase
      end
      // a stretch of phases with no idling on either side
      gaps_on = !(phase >= 6 && phase < 10);
      rows = $urandom_range(1, 4);
      write_row_length(len);
      repeat (rows) begin
        pat = $urandom_range(0, 1) ? PAT_RANDOM : sample_pattern_t'($urandom_range(0, 4));
        send_row(row_fill(len), pat);
        if ($urandom_range(0, 3) == 0) drain_results();
      end
      drain_results();
      phase++;
    end

    $display("Sent %0d samples over %0d row_length settings (0, 1, 16 and 31 among them),",
             samples_sent, $countones(lengths_seen));
    $display("checked %0d sorted values, including a %0d-cycle output hold-off.",
             values_checked, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("shell_sort_row test passed");
    end else begin
      $display("shell_sort_row test failed");
    end
    $finish;
  end

endmodule

// ----- shell_sort_row.f -----
sv/ssr_pkg.sv
sv/ssr_ctrl.sv
sv/ssr_dp.sv
sv/shell_sort_row.sv
tb/ssr_row_checker.sv
tb/testbench.sv
